// ===== hdl/asq_pkg.sv =====
// asq_pkg: shared types, constants and register codes of the aurora sample
// qualifier and scorer
// no dependencies; imported by every module of the block
package asq_pkg;

    // field widths
    localparam int CNT_W   = 16;
    localparam int CLR_W   = 11;
    localparam int WGT_W   = 9;
    localparam int STAT_W  = 4;
    localparam int SCORE_W = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int PW_W      = 13;

    // default history depth
    localparam int WINDOW_LEN_DEF = 8;

    // fixed-point constants
    localparam logic [WGT_W-1:0]   WEIGHT_ONE = 9'd256;
    localparam logic [CLR_W-1:0]   CLEAR_ONE  = 11'd1024;
    localparam logic [PW_W-1:0]    PW_ONE     = 13'd4096;
    localparam logic [7:0]         LINE_SCALE = 8'd150;
    localparam logic [8:0]         RATIO_INV  = 9'd500;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 22'h3FFFFF;

    // register reset values
    localparam logic [WGT_W-1:0] RST_LINE_WEIGHT  = 9'd128;
    localparam logic [CNT_W-1:0] RST_SPIKE_MARGIN = 16'd300;
    localparam logic [CNT_W-1:0] RST_HIST_SEED    = 16'd0;
    localparam logic [CNT_W-1:0] RST_FULL_STEP    = 16'd1000;
    localparam logic [CNT_W-1:0] RST_LINE_STEP    = 16'd35;
    localparam logic [CNT_W-1:0] RST_FULL_MAX     = 16'd3000;
    localparam logic [CNT_W-1:0] RST_LINE_MAX     = 16'd50;

    // result status codes, in check order
    typedef enum logic [STAT_W-1:0] {
        ST_SCORED,
        ST_FULL_STEP,
        ST_RATIO,
        ST_FULL_ZERO,
        ST_IR_ZERO,
        ST_DAYTIME,
        ST_SPIKE,
        ST_FULL_MAX,
        ST_LINE_STEP,
        ST_LINE_MAX
    } t_status;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WEIGHT,
        CFG_SPIKE_MARGIN,
        CFG_HIST_SEED,
        CFG_FULL_STEP,
        CFG_LINE_STEP,
        CFG_FULL_MAX,
        CFG_LINE_MAX
    } t_cfg_idx;

    // qualifier settings seen by the front end
    typedef struct packed {
        logic [WGT_W-1:0] line_weight;
        logic [CNT_W-1:0] spike_margin;
        logic [CNT_W-1:0] full_step_limit;
        logic [CNT_W-1:0] line_step_limit;
        logic [CNT_W-1:0] full_max;
        logic [CNT_W-1:0] line_max;
    } t_cfg;

    // history reseed request
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] value;
    } t_seed;

    // classified sample handed to the scorer
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] p;
        logic [WGT_W-1:0] w;
        logic             d_pos;
        logic [CNT_W-1:0] d;
        logic [CLR_W-1:0] clr;
    } t_job;

endpackage

// ===== hdl/asq_front.sv =====
// asq_front: accepts samples, runs the rejection chain and keeps the
// previous counts and the broadband history window
// depends on asq_pkg
module asq_front import asq_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CNT_W-1:0] i_ir,
    input  logic [CNT_W-1:0] i_full,
    input  logic [CNT_W-1:0] i_line,
    input  logic [CLR_W-1:0] i_clr,
    input  logic             i_night,
    input  t_cfg             i_cfg,
    input  t_seed            i_seed,
    input  logic             i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    localparam int SW  = CNT_W + $clog2(WINDOW_LEN);
    localparam int NW  = SW + 1;
    localparam int DL  = $clog2(2 * WINDOW_LEN);
    localparam int SH  = NW + DL;
    localparam int MW  = NW + 1;
    localparam int PRW = NW + MW;
    // rounded-up reciprocal of twice the window length, exact for NW-bit numerators
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(2 * WINDOW_LEN) - 64'd1) / 64'(2 * WINDOW_LEN));

    typedef enum logic [1:0] {F_IDLE, F_EVAL, F_DIV, F_PUSH} t_fstate;

    t_fstate r_state;
    logic [CNT_W-1:0] r_ir, r_full, r_line;
    logic [CLR_W-1:0] r_clr;
    logic             r_night;
    logic [CNT_W-1:0] r_prev_full, r_prev_line;
    logic             r_first;
    logic [CNT_W-1:0] r_win [WINDOW_LEN];
    logic [SW-1:0]    r_sum;
    logic [NW-1:0]    r_div_num;
    t_job             r_job;

    logic [CNT_W-1:0] w_pb, w_pl, w_dfull, w_dline;
    logic [24:0]      w_line500;
    logic [NW-1:0]    w_lhs, w_rhs, w_num;
    logic             w_spike;
    logic [17:0]      w_d;
    t_status          w_status;
    logic             w_reach;
    logic [PRW-1:0]   w_mprod;
    logic [CNT_W-1:0] w_mean;
    logic             w_shift;
    logic [CNT_W-1:0] w_entry;

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_q_full;
    assign o_job   = r_job;

    // step and ratio terms
    assign w_pb      = r_first ? r_full : r_prev_full;
    assign w_pl      = r_first ? r_line : r_prev_line;
    assign w_dfull   = (r_full > w_pb) ? r_full - w_pb : w_pb - r_full;
    assign w_dline   = (r_line > w_pl) ? r_line - w_pl : w_pl - r_line;
    assign w_line500 = 25'(r_line) * 25'(RATIO_INV);

    // spike compare against the window mean
    assign w_lhs   = NW'(r_full) * NW'(WINDOW_LEN);
    assign w_rhs   = NW'(r_sum) + NW'(i_cfg.spike_margin) * NW'(WINDOW_LEN);
    assign w_spike = w_lhs > w_rhs;
    assign w_num   = NW'(r_sum) + w_lhs;

    assign w_d = {2'b00, r_full} - {1'b0, r_ir, 1'b0};

    // rejection chain
    always_comb begin
        w_reach = 1'b0;
        if (w_dfull > i_cfg.full_step_limit) begin
            w_status = ST_FULL_STEP;
        end else if (r_full != '0 && w_line500 < 25'(r_full)) begin
            w_status = ST_RATIO;
        end else if (r_full == '0) begin
            w_status = ST_FULL_ZERO;
        end else if (r_ir == '0) begin
            w_status = ST_IR_ZERO;
        end else if (!r_night) begin
            w_status = ST_DAYTIME;
        end else begin
            w_reach = 1'b1;
            if (w_spike) begin
                w_status = ST_SPIKE;
            end else if (r_full > i_cfg.full_max) begin
                w_status = ST_FULL_MAX;
            end else if (w_dline > i_cfg.line_step_limit) begin
                w_status = ST_LINE_STEP;
            end else if (r_line > i_cfg.line_max) begin
                w_status = ST_LINE_MAX;
            end else begin
                w_status = ST_SCORED;
            end
        end
    end

    // spike entry: floored mean of window mean and sample by reciprocal multiply
    assign w_mprod = PRW'(r_div_num) * PRW'(RECIP);
    assign w_mean  = w_mprod[SH +: CNT_W];

    assign w_shift = ((r_state == F_EVAL) && w_reach && !w_spike)
                   || (r_state == F_DIV);
    assign w_entry = (r_state == F_EVAL) ? r_full : w_mean;

    // sequencer, sample and previous-count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_prev_full <= '0;
            r_prev_line <= '0;
            r_first     <= 1'b1;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_ir    <= i_ir;
                        r_full  <= i_full;
                        r_line  <= i_line;
                        r_clr   <= i_clr;
                        r_night <= i_night;
                        r_state <= F_EVAL;
                    end
                end
                F_EVAL: begin
                    r_job.status <= w_status;
                    r_job.p      <= w_pl;
                    r_job.w      <= (i_cfg.line_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                                     : i_cfg.line_weight;
                    r_job.d_pos  <= !w_d[17] && (w_d != '0);
                    r_job.d      <= w_d[CNT_W-1:0];
                    r_job.clr    <= (r_clr > CLEAR_ONE) ? CLEAR_ONE : r_clr;
                    r_prev_full  <= r_full;
                    r_prev_line  <= r_line;
                    r_first      <= 1'b0;
                    r_div_num    <= w_num;
                    r_state      <= (w_reach && w_spike) ? F_DIV : F_PUSH;
                end
                F_DIV: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // history window and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= RST_HIST_SEED;
            end
            r_sum <= SW'(RST_HIST_SEED) * SW'(WINDOW_LEN);
        end else if (i_seed.we) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= i_seed.value;
            end
            r_sum <= SW'(i_seed.value) * SW'(WINDOW_LEN);
        end else if (w_shift) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_LEN-1] <= w_entry;
            r_sum <= r_sum - SW'(r_win[0]) + SW'(w_entry);
        end
    end

endmodule

// ===== hdl/asq_fifo.sv =====
// asq_fifo: two-entry queue of classified samples between front and scorer
// depends on asq_pkg
module asq_fifo import asq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_job   = r_mem[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/asq_back.sv =====
// asq_back: scorer; numerator products, clear-sky power search and final
// scaling share one multiplier, beside a divider and the output register
// depends on asq_pkg
module asq_back import asq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [SCORE_W-1:0] o_score
);

    typedef enum logic [3:0] {
        B_IDLE, B_NUM0, B_NUM1, B_A, B_DIV, B_CPOW, B_SQ0, B_SQ, B_CMP, B_FIN, B_OUT
    } t_bstate;

    t_bstate            r_state;
    t_job               r_job;
    logic [31:0]        r_num;
    logic [CNT_W-1:0]   r_rem;
    logic [24:0]        r_a;
    logic [60:0]        r_c6;
    logic [63:0]        r_pow;
    logic [PW_W-1:0]    r_pw;
    logic [3:0]         r_bit;
    logic [4:0]         r_cnt;
    logic [SCORE_W-1:0] r_res;
    logic               r_valid;
    logic [STAT_W-1:0]  r_status;
    logic [SCORE_W-1:0] r_score;

    logic [50:0]     w_ma;
    logic [12:0]     w_mb;
    logic [63:0]     w_prod;
    logic [PW_W-1:0] w_cand;
    logic [16:0]     w_trial;
    logic            w_ge;
    logic            w_load;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_score  = r_score;

    assign w_cand  = r_pw | (PW_W'(1) << r_bit);
    assign w_trial = {r_rem, r_num[31]};
    assign w_ge    = w_trial >= {1'b0, r_job.d};
    assign w_load  = (r_state == B_OUT) && (!r_valid || i_ready);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            B_NUM0: begin
                w_ma = 51'(r_job.p);
                w_mb = 13'(WEIGHT_ONE - r_job.w);
            end
            B_NUM1: begin
                w_ma = 51'(r_num);
                w_mb = 13'(LINE_SCALE);
            end
            B_A: begin
                w_ma = 51'(r_job.p);
                w_mb = 13'(r_job.w);
            end
            B_CPOW: begin
                w_ma = r_c6[50:0];
                w_mb = 13'(r_job.clr);
            end
            B_SQ: begin
                w_ma = r_pow[50:0];
                w_mb = w_cand;
            end
            B_FIN: begin
                w_ma = 51'(r_a) + 51'(r_num);
                w_mb = r_pw;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);

    // scoring sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready && !w_load) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_res <= '0;
                        r_state <= (i_job.status == ST_SCORED) ? B_NUM0 : B_OUT;
                    end
                end
                B_NUM0: begin
                    r_num   <= w_prod[31:0];
                    r_state <= B_NUM1;
                end
                B_NUM1: begin
                    r_num   <= w_prod[31:0];
                    r_state <= B_A;
                end
                B_A: begin
                    r_a   <= w_prod[24:0];
                    r_rem <= '0;
                    r_cnt <= '0;
                    if (r_job.d_pos) begin
                        r_state <= B_DIV;
                    end else begin
                        r_num   <= '0;
                        r_c6    <= 61'(r_job.clr);
                        r_state <= B_CPOW;
                    end
                end
                B_DIV: begin
                    r_rem <= w_ge ? 16'(w_trial - {1'b0, r_job.d}) : w_trial[15:0];
                    r_num <= {r_num[30:0], w_ge};
                    if (r_cnt == 5'd31) begin
                        r_c6    <= 61'(r_job.clr);
                        r_cnt   <= '0;
                        r_state <= B_CPOW;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                // clear level raised to the sixth power
                B_CPOW: begin
                    r_c6  <= w_prod[60:0];
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd4) begin
                        r_pw    <= '0;
                        r_bit   <= 4'd12;
                        r_state <= B_SQ0;
                    end
                end
                B_SQ0: begin
                    r_pow   <= 64'(w_cand);
                    r_cnt   <= '0;
                    r_state <= B_SQ;
                end
                // candidate raised to the fifth power
                B_SQ: begin
                    r_pow <= w_prod;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd3) begin
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    if (w_cand <= PW_ONE && r_pow <= 64'(r_c6)) begin
                        r_pw <= w_cand;
                    end
                    if (r_bit == '0) begin
                        r_state <= B_FIN;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_state <= B_SQ0;
                    end
                end
                B_FIN: begin
                    r_res   <= (w_prod[63:12] > 52'(SCORE_MAX)) ? SCORE_MAX
                                                                : w_prod[SCORE_W+11:12];
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_load) begin
                        r_status <= r_job.status;
                        r_score  <= r_res;
                        r_valid  <= 1'b1;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/aurora_sample_qualifier_scorer_top.sv =====
// aurora_sample_qualifier_scorer_top: register file, qualifier front end,
// job queue and scorer
// depends on asq_pkg, asq_front, asq_fifo, asq_back
//
//  channel   direction  payload
//  s_axis    in         tdata: infrared, broadband, line, clear; tuser: is_night
//  m_axis    out        tdata: score; tuser: status
//  cfg       in         i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// the front end takes a new sample only when idle and adds a divide state when
// a spike entry goes through the reciprocal multiply; the scorer sends a
// rejected sample straight to the output register and a scored one through
// the 32-step divider (only with a positive denominator) and the 13-step
// clear-sky power search on the shared multiplier; reset is synchronous, active
// low; the queue lets the front keep qualifying while scorer or output stalls
module aurora_sample_qualifier_scorer_top import asq_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] infrared_count, [31:16] broadband_count, [47:32] line_count,
    // [58:48] clear_level, [63:59] zero
    input  logic [63:0]          s_axis_tdata,
    // [0] is_night
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [21:0] score, [23:22] zero
    output logic [23:0]          m_axis_tdata,
    // [3:0] status
    output logic [STAT_W-1:0]    m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    t_seed w_seed;
    t_job  w_push_job, w_pop_job;
    logic  w_push, w_pop, w_full, w_empty;
    logic [SCORE_W-1:0] w_score;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_weight     <= RST_LINE_WEIGHT;
            r_cfg.spike_margin    <= RST_SPIKE_MARGIN;
            r_cfg.full_step_limit <= RST_FULL_STEP;
            r_cfg.line_step_limit <= RST_LINE_STEP;
            r_cfg.full_max        <= RST_FULL_MAX;
            r_cfg.line_max        <= RST_LINE_MAX;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LINE_WEIGHT:  r_cfg.line_weight     <= i_cfg_data[WGT_W-1:0];
                CFG_SPIKE_MARGIN: r_cfg.spike_margin    <= i_cfg_data;
                CFG_FULL_STEP:    r_cfg.full_step_limit <= i_cfg_data;
                CFG_LINE_STEP:    r_cfg.line_step_limit <= i_cfg_data;
                CFG_FULL_MAX:     r_cfg.full_max        <= i_cfg_data;
                CFG_LINE_MAX:     r_cfg.line_max        <= i_cfg_data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    // a history seed write refills the window at once
    assign w_seed.we    = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_HIST_SEED);
    assign w_seed.value = i_cfg_data;

    asq_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_ir     (s_axis_tdata[15:0]),
        .i_full   (s_axis_tdata[31:16]),
        .i_line   (s_axis_tdata[47:32]),
        .i_clr    (s_axis_tdata[58:48]),
        .i_night  (s_axis_tuser),
        .i_cfg    (r_cfg),
        .i_seed   (w_seed),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    asq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    asq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_pop_job),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_status (m_axis_tuser),
        .o_score  (w_score)
    );

    assign m_axis_tdata = {2'b00, w_score};

    // a rejected sample never carries a score
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_SCORED) |-> (m_axis_tdata == '0))
        else $error("rejected sample with nonzero score");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue overflow");

    // the scorer only pops a queue that holds a job
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job queue underflow");

endmodule

// ===== tb/sv/aurora_sample_qualifier_scorer_top_tb.sv =====
// aurora_sample_qualifier_scorer_top_tb: self-checking bench for the sample
// qualifier and scorer, with an in-order predictor and randomized stalls
// depends on asq_pkg and aurora_sample_qualifier_scorer_top
module aurora_sample_qualifier_scorer_top_tb;
    import asq_pkg::*;

    localparam int WLEN = WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_status          status;
        logic [SCORE_W-1:0] score;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    aurora_sample_qualifier_scorer_top u_top (.*);

    // predictor state and settings
    logic [WGT_W-1:0] weight_q;
    logic [15:0]      spike_lim_q, seed_q, full_step_q, line_step_q, full_max_q, line_max_q;
    logic [15:0]      last_full, last_line;
    logic             first_q;
    logic [15:0]      hist [WLEN];
    logic [18:0]      hist_sum;

    t_result          expected_results [$];
    int               mismatches;
    int               cycles;
    bit               allow_idle;
    int               sink_hold;

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void reseed_history();
        for (int i = 0; i < WLEN; i++) hist[i] = seed_q;
        hist_sum = 19'(seed_q) * 19'(WLEN);
    endfunction

    // largest r, at most 4096, with r^5 <= c^6
    function automatic logic [12:0] clear_power(logic [10:0] c);
        longint unsigned c6, lo, hi, mid;
        c6 = longint'(c) * c * c * c * c * c;
        lo = 0;
        hi = 4096;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * mid * mid * mid <= c6) lo = mid;
            else hi = mid - 1;
        end
        return lo[12:0];
    endfunction

    // returns 1 on spike and shifts the history
    function automatic bit history_spike(logic [15:0] v);
        longint unsigned lhs, rhs;
        logic [15:0] ent;
        bit hit;
        lhs = longint'(v) * WLEN;
        rhs = longint'(hist_sum) + longint'(spike_lim_q) * WLEN;
        hit = lhs > rhs;
        ent = hit ? 16'((longint'(hist_sum) + lhs) / (2 * WLEN)) : v;
        hist_sum = hist_sum - hist[0];
        for (int i = 0; i < WLEN - 1; i++) hist[i] = hist[i+1];
        hist[WLEN-1] = ent;
        hist_sum = hist_sum + ent;
        return hit;
    endfunction

    function automatic t_result qualify_sample(logic [15:0] ir, logic [15:0] full,
                                               logic [15:0] line, logic [10:0] clr, logic night);
        t_result r;
        int dfull, dline, d;
        longint unsigned w, p, a, b, s;
        logic [10:0] c;
        if (first_q) begin
            last_full = full;
            last_line = line;
            first_q = 1'b0;
        end
        dfull = full > last_full ? full - last_full : last_full - full;
        dline = line > last_line ? line - last_line : last_line - line;
        r.status = ST_SCORED;
        r.score = '0;
        if (dfull > full_step_q) r.status = ST_FULL_STEP;
        else if (full != 0 && longint'(line) * 500 < full) r.status = ST_RATIO;
        else if (full == 0) r.status = ST_FULL_ZERO;
        else if (ir == 0) r.status = ST_IR_ZERO;
        else if (!night) r.status = ST_DAYTIME;
        else if (history_spike(full)) r.status = ST_SPIKE;
        else if (full > full_max_q) r.status = ST_FULL_MAX;
        else if (dline > line_step_q) r.status = ST_LINE_STEP;
        else if (line > line_max_q) r.status = ST_LINE_MAX;
        if (r.status == ST_SCORED) begin
            w = weight_q > 256 ? 256 : weight_q;
            p = last_line;
            a = p * w;
            b = 0;
            d = int'(full) - 2 * int'(ir);
            c = clr > 1024 ? 11'd1024 : clr;
            if (d > 0) b = (p * 150 * (256 - w)) / longint'(d);
            s = ((a + b) * clear_power(c)) >> 12;
            r.score = s > 64'h3FFFFF ? SCORE_MAX : s[21:0];
        end
        last_full = full;
        last_line = line;
        return r;
    endfunction

    // wait for every result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // registers are only written with nothing in flight
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LINE_WEIGHT:  weight_q    = val[8:0];
            CFG_SPIKE_MARGIN: spike_lim_q = val;
            CFG_HIST_SEED: begin
                seed_q = val;
                reseed_history();
            end
            CFG_FULL_STEP:    full_step_q = val;
            CFG_LINE_STEP:    line_step_q = val;
            CFG_FULL_MAX:     full_max_q  = val;
            CFG_LINE_MAX:     line_max_q  = val;
            default: ;
        endcase
    endtask

    // tvalid stays up after a beat until the next sample, an idle burst or a drain
    task automatic send_sample(logic [15:0] ir, logic [15:0] full, logic [15:0] line,
                               logic [10:0] clr, logic night);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, clr, line, full, ir};
        s_axis_tuser  <= night;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(qualify_sample(ir, full, line, clr, night));
        @(negedge i_clk);
    endtask

    // sink stalls at random while idling is allowed
    always @(negedge i_clk) begin
        if (!allow_idle) begin
            m_axis_tready <= 1'b1;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            if (sink_hold == 0) m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = $urandom_range(1, 12);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser);
            got.score  = m_axis_tdata[21:0];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d score %0d", got.status, got.score);
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status || got.score != want.score
                        || m_axis_tdata[23:22] != 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d score %0d, got %0d %0d",
                                 want.status, want.score, got.status, got.score);
                end
            end
        end
    end

    // random in-range-ish sample near the last one, mostly well formed
    task automatic random_samples(int n);
        logic [15:0] ir, full, line;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                ir = 16'($urandom); full = 16'($urandom); line = 16'($urandom);
                send_sample(ir, full, line, 11'($urandom), 1'($urandom));
            end else begin
                full = 16'($urandom_range(0, 1) ? last_full + $urandom_range(0, 400)
                                                : last_full - $urandom_range(0, 400));
                if (full == 0 || full > 4000) full = 16'($urandom_range(500, 2500));
                line = 16'($urandom_range(full / 500 + 1, full / 500 + 45));
                ir   = $urandom_range(0, 40) == 0 ? 16'd0 : 16'($urandom_range(1, full));
                send_sample(ir, full, line, 11'($urandom_range(0, 1100)),
                            $urandom_range(0, 15) != 0);
            end
        end
    endtask

    task automatic test_directed();
        send_sample(16'd100, 16'd1000, 16'd20, 11'd1024, 1'b1);   // first sample
        send_sample(16'd100, 16'd3000, 16'd20, 11'd1024, 1'b1);   // big step
        send_sample(16'd100, 16'd1000, 16'd1, 11'd512, 1'b1);     // low ratio, but rejected as a big step
        send_sample(16'd100, 16'd0, 16'd0, 11'd512, 1'b1);        // zero broadband
        send_sample(16'd0, 16'd500, 16'd10, 11'd512, 1'b1);       // zero infrared
        send_sample(16'd100, 16'd500, 16'd10, 11'd512, 1'b0);     // daytime
        send_sample(16'd100, 16'd1400, 16'd10, 11'd2047, 1'b1);   // spike
        send_sample(16'd100, 16'd600, 16'd10, 11'd0, 1'b1);
        send_sample(16'd100, 16'd600, 16'd60, 11'd700, 1'b1);     // line step, but rejected as a spike
        send_sample(16'd400, 16'd600, 16'd60, 11'd1024, 1'b1);    // d not positive, but rejected as a spike
        write_reg(CFG_LINE_STEP, 16'hFFFF);
        send_sample(16'd100, 16'd650, 16'd90, 11'd1024, 1'b1);    // line too high, but rejected as a spike
        drain();
    endtask

    task automatic test_extremes();
        write_reg(CFG_LINE_WEIGHT, 16'h1FF);
        write_reg(CFG_SPIKE_MARGIN, 16'hFFFF);
        write_reg(CFG_HIST_SEED, 16'hFFFF);
        write_reg(CFG_FULL_STEP, 16'hFFFF);
        write_reg(CFG_FULL_MAX, 16'hFFFF);
        write_reg(CFG_LINE_MAX, 16'hFFFF);
        send_sample(16'd1, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd1024, 1'b1);
        write_reg(CFG_LINE_WEIGHT, 16'd0);
        send_sample(16'd1, 16'hFFFF, 16'hFFFF, 11'd1024, 1'b1);
        send_sample(16'd1, 16'd3, 16'hFFFF, 11'd1023, 1'b1);
        drain();
        write_reg(CFG_FULL_STEP, 16'd0);
        write_reg(CFG_SPIKE_MARGIN, 16'd0);
        write_reg(CFG_LINE_STEP, 16'd0);
        write_reg(CFG_FULL_MAX, 16'd0);
        write_reg(CFG_LINE_MAX, 16'd0);
        write_reg(CFG_HIST_SEED, 16'd0);
        send_sample(16'd1, 16'd3, 16'd1, 11'd1, 1'b1);
        send_sample(16'd1, 16'd3, 16'd1, 11'd1, 1'b1);
        drain();
    endtask

    task automatic test_random_defaults();
        write_reg(CFG_LINE_WEIGHT, 16'd128);
        write_reg(CFG_SPIKE_MARGIN, 16'd300);
        write_reg(CFG_HIST_SEED, 16'd1500);
        write_reg(CFG_FULL_STEP, 16'd1000);
        write_reg(CFG_LINE_STEP, 16'd35);
        write_reg(CFG_FULL_MAX, 16'd3000);
        write_reg(CFG_LINE_MAX, 16'd50);
        allow_idle = 1'b1;
        random_samples(500);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LINE_WEIGHT, 16'($urandom_range(0, 511)));
            write_reg(CFG_SPIKE_MARGIN, 16'($urandom_range(0, 800)));
            write_reg(CFG_HIST_SEED, 16'($urandom_range(0, 3000)));
            write_reg(CFG_FULL_STEP, 16'($urandom_range(100, 2000)));
            write_reg(CFG_LINE_STEP, 16'($urandom_range(5, 80)));
            write_reg(CFG_FULL_MAX, 16'($urandom_range(1000, 4000)));
            write_reg(CFG_LINE_MAX, 16'($urandom_range(10, 100)));
            random_samples(175);
            drain();
        end
    endtask

    task automatic test_no_idle();
        allow_idle = 1'b0;
        random_samples(200);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LINE_WEIGHT;
        i_cfg_data = '0;
        allow_idle = 1'b0;
        sink_hold = 0;
        mismatches = 0;
        cycles = 0;
        weight_q = RST_LINE_WEIGHT;
        spike_lim_q = RST_SPIKE_MARGIN;
        seed_q = RST_HIST_SEED;
        full_step_q = RST_FULL_STEP;
        line_step_q = RST_LINE_STEP;
        full_max_q = RST_FULL_MAX;
        line_max_q = RST_LINE_MAX;
        last_full = '0;
        last_line = '0;
        first_q = 1'b1;
        reseed_history();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_extremes();
        test_random_defaults();
        test_random_settings();
        test_no_idle();
        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/asq_pkg.sv
hdl/asq_front.sv
hdl/asq_fifo.sv
hdl/asq_back.sv
hdl/aurora_sample_qualifier_scorer_top.sv
tb/sv/aurora_sample_qualifier_scorer_top_tb.sv
